@@ rtl/cppt_pkg.sv @@
// Shared types and constants for the convex polygon point test.
// Holds the item codes, controller states and the command/status structs
// that join the controller to the datapath. No dependencies.
package cppt_pkg;

  // Defaults for the top level parameters
  localparam int DEF_MAX_EDGES   = 16;
  localparam int DEF_COORD_WIDTH = 16;

  // Item kind carried on in_tuser
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Sign of one cross product
  typedef enum logic [1:0] {
    SGN_ZERO = 2'd0,
    SGN_POS  = 2'd1,
    SGN_NEG  = 2'd2
  } sign_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_WALK  = 2'd1,
    ST_DRAIN = 2'd2,
    ST_DONE  = 2'd3
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // latch the accepted word, restart the edge walk
    logic issue;   // read the next edge and advance the walk index
    logic commit;  // apply the item and load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_is_query;  // word on the input port is a query
    logic table_empty;  // no edges stored
    logic walk_last;    // current walk index is the last stored edge
    logic pipe_busy;    // cross product pipeline still holds an edge
    logic out_free;     // result register can take a new word
  } sts_t;

endpackage

@@ rtl/convex_polygon_point_test.sv @@
// Convex polygon point test, top level: controller plus datapath.
// Flow: an add, clear or spare code is latched and then committed; a query on N > 0 stored
// edges walks them, one edge read per cycle into a four-stage pipe, drains the pipe and then
// commits (an empty table commits straight away). One item at a time: a result that waits in
// the output register holds the next item in its commit state.
// Reset (rst_n low, synchronous) empties the table and resets the box.
module convex_polygon_point_test
  import cppt_pkg::*;
#(
  parameter int MAX_EDGES   = DEF_MAX_EDGES,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  localparam int CNT_W  = $clog2(MAX_EDGES + 1),
  localparam int IN_W   = ((4 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W  = ((2 + CNT_W + 4 * COORD_WIDTH + 7) / 8) * 8
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // x, y, dx, dy
  input  logic [1:0]       in_tuser,   // op
  output logic             out_tvalid,
  input  logic             out_tready,
  // inside_res, status, edge_total, box_min_x, box_min_y, box_max_x, box_max_y
  output logic [OUT_W-1:0] out_tdata
);

  cmd_t cmd;
  sts_t sts;

  cppt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cppt_datapath #(
    .MAX_EDGES   (MAX_EDGES),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

@@ rtl/cppt_ctrl.sv @@
// Controller state machine for the convex polygon point test.
// Sequences the edge walk of a query and the commit of every item.
// Depends on cppt_pkg.
module cppt_ctrl
  import cppt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (sts.in_is_query && !sts.table_empty) begin
            state_nxt = ST_WALK;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        // issue one edge per cycle
        cmd.issue = 1'b1;
        if (sts.walk_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/cppt_datapath.sv @@
// Datapath for the convex polygon point test: edge memory, bounding box,
// edge count, cross product pipeline and the result register.
// Depends on cppt_pkg; driven by cppt_ctrl commands.
module cppt_datapath
  import cppt_pkg::*;
#(
  parameter int MAX_EDGES   = DEF_MAX_EDGES,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  localparam int CNT_W  = $clog2(MAX_EDGES + 1),
  localparam int AW     = $clog2(MAX_EDGES),
  localparam int IN_W   = ((4 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W  = ((2 + CNT_W + 4 * COORD_WIDTH + 7) / 8) * 8
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic [1:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  input  cmd_t             cmd,
  output sts_t             sts
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;          // point minus edge start
  localparam int PW  = CW + DW;         // one product
  localparam int EW  = 4 * CW;          // one stored edge

  localparam logic signed [CW-1:0] COORD_TOP    = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_BOTTOM = {1'b1, {(CW-1){1'b0}}};

  // Latched item
  op_t                 op_r;
  logic signed [CW-1:0] x_r, y_r, dx_r, dy_r;

  // Table state
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic signed [CW-1:0] lo_x_r, lo_y_r, hi_x_r, hi_y_r;
  logic signed [CW-1:0] lo_x_nxt, lo_y_nxt, hi_x_nxt, hi_y_nxt;
  logic [EW-1:0]        mem [MAX_EDGES];
  logic                 mem_we;
  logic                 full;

  // Walk and pipeline
  logic [CNT_W-1:0]     idx_r;
  logic [EW-1:0]        rd_data_r;
  logic                 v1_r, v2_r, v3_r;
  logic signed [CW-1:0] ex, ey, evx, evy;
  logic signed [DW-1:0] dxq_r, dyq_r;
  logic signed [CW-1:0] vx_r, vy_r;
  logic signed [PW-1:0] p_r, q_r;
  sign_t                s_cur, ref_r;
  logic                 fail_r;

  // Result register
  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_data_r;
  logic                 res_inside, res_status;

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_t'(in_tuser);
      x_r  <= in_tdata[CW-1:0];
      y_r  <= in_tdata[2*CW-1:CW];
      dx_r <= in_tdata[3*CW-1:2*CW];
      dy_r <= in_tdata[4*CW-1:3*CW];
    end
  end

  // Apply the item to count and box
  always_comb begin
    full      = (count_r == CNT_W'(MAX_EDGES));
    count_nxt = count_r;
    lo_x_nxt  = lo_x_r;
    lo_y_nxt  = lo_y_r;
    hi_x_nxt  = hi_x_r;
    hi_y_nxt  = hi_y_r;
    mem_we    = 1'b0;
    case (op_r)
      OP_ADD: begin
        if (!full) begin
          mem_we    = cmd.commit;
          count_nxt = count_r + CNT_W'(1);
          if (x_r < lo_x_r) lo_x_nxt = x_r;
          if (y_r < lo_y_r) lo_y_nxt = y_r;
          if (x_r > hi_x_r) hi_x_nxt = x_r;
          if (y_r > hi_y_r) hi_y_nxt = y_r;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
        lo_x_nxt  = COORD_TOP;
        lo_y_nxt  = COORD_TOP;
        hi_x_nxt  = COORD_BOTTOM;
        hi_y_nxt  = COORD_BOTTOM;
      end
      default: begin
      end
    endcase
  end

  // Table state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      lo_x_r  <= COORD_TOP;
      lo_y_r  <= COORD_TOP;
      hi_x_r  <= COORD_BOTTOM;
      hi_y_r  <= COORD_BOTTOM;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
      lo_x_r  <= lo_x_nxt;
      lo_y_r  <= lo_y_nxt;
      hi_x_r  <= hi_x_nxt;
      hi_y_r  <= hi_y_nxt;
    end
  end

  // Edge memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= {dy_r, dx_r, y_r, x_r};
    end
    if (cmd.issue) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  // Walk index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.issue) begin
      idx_r <= idx_r + CNT_W'(1);
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage 2: point relative to edge start
  assign ex  = rd_data_r[CW-1:0];
  assign ey  = rd_data_r[2*CW-1:CW];
  assign evx = rd_data_r[3*CW-1:2*CW];
  assign evy = rd_data_r[4*CW-1:3*CW];

  always_ff @(posedge clk) begin
    if (v1_r) begin
      dxq_r <= DW'(x_r) - DW'(ex);
      dyq_r <= DW'(y_r) - DW'(ey);
      vx_r  <= evx;
      vy_r  <= evy;
    end
  end

  // Stage 3: the two products of the cross
  always_ff @(posedge clk) begin
    if (v2_r) begin
      p_r <= PW'(vx_r) * PW'(dyq_r);
      q_r <= PW'(vy_r) * PW'(dxq_r);
    end
  end

  // Stage 4: compare and track the reference sign
  always_comb begin
    if (p_r > q_r) begin
      s_cur = SGN_POS;
    end else if (p_r < q_r) begin
      s_cur = SGN_NEG;
    end else begin
      s_cur = SGN_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r  <= SGN_ZERO;
      fail_r <= 1'b0;
    end else if (cmd.load) begin
      ref_r  <= SGN_ZERO;
      fail_r <= 1'b0;
    end else if (v3_r) begin
      if (ref_r == SGN_ZERO) begin
        ref_r <= s_cur;
      end else if (s_cur != ref_r) begin
        fail_r <= 1'b1;
      end
    end
  end

  // Result register
  assign res_inside = (op_r == OP_QUERY) && (count_r != '0) && !fail_r;
  assign res_status = (op_r == OP_ADD) && full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= OUT_W'({hi_y_nxt, hi_x_nxt, lo_y_nxt, lo_x_nxt,
                            count_nxt, res_status, res_inside});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Status to the controller
  assign sts.in_is_query = (in_tuser == OP_QUERY);
  assign sts.table_empty = (count_r == '0);
  assign sts.walk_last   = (idx_r + CNT_W'(1) == count_r);
  assign sts.pipe_busy   = v1_r | v2_r | v3_r;
  assign sts.out_free    = !out_valid_r || out_tready;

endmodule
